// File: src/i2c_master_bit_engine_assert.svh
// Assertion helpers shared by the bit engine modules.
// Both expect clk and rst (synchronous, active high) in scope.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

  // command codes
  localparam logic [2:0] FUNC_NONE  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_WACK  = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  // configuration register indexes
  localparam logic REG_UNIT_TICKS  = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] UNIT_TICKS_RST  = 16'd10;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

  typedef struct packed {
    logic [15:0] unit_ticks;
    logic [7:0]  ack_timeout;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/i2c_master_bit_engine.sv
// A result word is registered into res, or parked in the skid word while res is stalled.
// Throughput: one command word per cycle while cmd_stall is low; a two-deep output buffer keeps cmd_stall
// low for one extra word while res is stalled.
// Reset (rst, synchronous): bus state idle with SCL and SDA high and driven,
// unit_ticks 10, ack_timeout 250, output buffer empty.
`default_nettype none

`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_t        cmd,
  output logic             res_valid,
  input  wire logic        res_stall,
  output res_t             res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t cfg;
  res_t step_res;
  res_t skid;
  logic skid_valid;
  logic accept;
  logic take;

  assign cfg_ready = 1'b1;
  assign cmd_stall = skid_valid;
  assign accept    = cmd_valid && !skid_valid;
  assign take      = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_ticks  <= UNIT_TICKS_RST;
      cfg.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UNIT_TICKS:  cfg.unit_ticks  <= cfg_data;
        REG_ACK_TIMEOUT: cfg.ack_timeout <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  i2cm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (accept),
    .cmd  (cmd),
    .res  (step_res)
  );

  // output register plus skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !res_valid) begin
      if (skid_valid) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept;
        if (accept) begin
          res <= step_res;
        end
      end
    end else if (accept) begin
      skid       <= step_res;
      skid_valid <= 1'b1;
    end
  end

  `I2CM_ASSERT_IMP(a_skid_behind_out, skid_valid, res_valid,
                   "skid word held with output register empty")
  `I2CM_ASSERT_NXT(a_skid_fill, res_valid && res_stall && accept, skid_valid,
                   "word taken while output stalled was not parked")
  `I2CM_ASSERT_IMP(a_done_not_busy, res_valid && res.done_res, !res.busy_res,
                   "done pulse while still busy")

endmodule

`default_nettype wire

// File: src/i2cm_core.sv
`default_nettype none

`include "i2c_master_bit_engine_assert.svh"

module i2cm_core
  import i2cm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic step,
  input  wire cmd_t cmd,
  output res_t      res
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_A  = 4'd1;
  localparam logic [3:0] PH_START_B  = 4'd2;
  localparam logic [3:0] PH_STOP_A   = 4'd3;
  localparam logic [3:0] PH_STOP_B   = 4'd4;
  localparam logic [3:0] PH_WR_SETUP = 4'd5;
  localparam logic [3:0] PH_WR_HIGH  = 4'd6;
  localparam logic [3:0] PH_WR_LOW   = 4'd7;
  localparam logic [3:0] PH_ACK_SET  = 4'd8;
  localparam logic [3:0] PH_POLL     = 4'd9;
  localparam logic [3:0] PH_RD_LOW   = 4'd10;
  localparam logic [3:0] PH_RD_HIGH  = 4'd11;
  localparam logic [3:0] PH_AK_LOW   = 4'd12;
  localparam logic [3:0] PH_AK_HIGH  = 4'd13;

  logic [3:0]  phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [15:0] wait_count, wait_count_next;
  logic [2:0]  unit_left, unit_left_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [7:0]  poll_count, poll_count_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        drive_reg, drive_reg_next;
  logic        ack_fail_reg, ack_fail_reg_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        ack_choice, ack_choice_next;
  logic        done;

  logic [15:0] limit;
  logic [16:0] wait_inc;
  logic        roll;
  logic [2:0]  unit_dec;
  logic        expired;
  logic [8:0]  poll_inc;
  logic [3:0]  bit_inc;

  // delay timer: a unit ends when the tick count reaches unit_ticks (zero acts as one)
  assign limit    = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
  assign wait_inc = {1'b0, wait_count} + 17'd1;
  assign roll     = wait_inc >= {1'b0, limit};
  assign unit_dec = (unit_left != 3'd0) ? unit_left - 3'd1 : 3'd0;
  assign expired  = roll && (unit_dec == 3'd0);
  assign poll_inc = {1'b0, poll_count} + 9'd1;
  assign bit_inc  = bit_count + 4'd1;

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    wait_count_next   = wait_count;
    unit_left_next    = unit_left;
    shift_reg_next    = shift_reg;
    poll_count_next   = poll_count;
    scl_reg_next      = scl_reg;
    sda_reg_next      = sda_reg;
    drive_reg_next    = drive_reg;
    ack_fail_reg_next = ack_fail_reg;
    rx_hold_next      = rx_hold;
    ack_choice_next   = ack_choice;
    done              = 1'b0;

    if (phase == PH_IDLE) begin
      case (cmd.func)
        FUNC_START: begin
          drive_reg_next  = 1'b1;
          sda_reg_next    = 1'b1;
          scl_reg_next    = 1'b1;
          unit_left_next  = 3'd4;
          wait_count_next = '0;
          phase_next      = PH_START_A;
        end
        FUNC_STOP: begin
          drive_reg_next  = 1'b1;
          scl_reg_next    = 1'b0;
          sda_reg_next    = 1'b0;
          unit_left_next  = 3'd4;
          wait_count_next = '0;
          phase_next      = PH_STOP_A;
        end
        FUNC_WRITE: begin
          drive_reg_next  = 1'b1;
          scl_reg_next    = 1'b0;
          sda_reg_next    = cmd.tx_byte[7];
          shift_reg_next  = {cmd.tx_byte[6:0], 1'b0};
          bit_count_next  = '0;
          unit_left_next  = 3'd2;
          wait_count_next = '0;
          phase_next      = PH_WR_SETUP;
        end
        FUNC_WACK: begin
          ack_fail_reg_next = 1'b0;
          drive_reg_next    = 1'b0;
          sda_reg_next      = 1'b1;
          scl_reg_next      = 1'b1;
          unit_left_next    = 3'd2;
          wait_count_next   = '0;
          phase_next        = PH_ACK_SET;
        end
        FUNC_READ: begin
          drive_reg_next  = 1'b0;
          sda_reg_next    = 1'b1;
          scl_reg_next    = 1'b0;
          bit_count_next  = '0;
          shift_reg_next  = '0;
          ack_choice_next = cmd.send_ack;
          unit_left_next  = 3'd2;
          wait_count_next = '0;
          phase_next      = PH_RD_LOW;
        end
        default: ;
      endcase
    end else if (phase == PH_POLL) begin
      if (!cmd.sda_in) begin
        scl_reg_next = 1'b0;
        phase_next   = PH_IDLE;
        done         = 1'b1;
      end else if (poll_inc > {1'b0, cfg.ack_timeout}) begin
        // no acknowledge in time: flag it and run a stop condition
        ack_fail_reg_next = 1'b1;
        poll_count_next   = '0;
        drive_reg_next    = 1'b1;
        scl_reg_next      = 1'b0;
        sda_reg_next      = 1'b0;
        unit_left_next    = 3'd4;
        wait_count_next   = '0;
        phase_next        = PH_STOP_A;
      end else begin
        poll_count_next = poll_inc[7:0];
      end
    end else if (phase > PH_AK_HIGH) begin
      phase_next = PH_IDLE;
    end else begin
      if (roll) begin
        wait_count_next = '0;
        unit_left_next  = unit_dec;
      end else begin
        wait_count_next = wait_inc[15:0];
      end
      if (expired) begin
        case (phase)
          PH_START_A: begin
            sda_reg_next    = 1'b0;
            unit_left_next  = 3'd4;
            wait_count_next = '0;
            phase_next      = PH_START_B;
          end
          PH_START_B: begin
            scl_reg_next = 1'b0;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_STOP_A: begin
            scl_reg_next    = 1'b1;
            unit_left_next  = 3'd4;
            wait_count_next = '0;
            phase_next      = PH_STOP_B;
          end
          PH_STOP_B: begin
            sda_reg_next = 1'b1;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_WR_SETUP: begin
            scl_reg_next    = 1'b1;
            unit_left_next  = 3'd2;
            wait_count_next = '0;
            phase_next      = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            scl_reg_next    = 1'b0;
            unit_left_next  = 3'd2;
            wait_count_next = '0;
            phase_next      = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            bit_count_next = bit_inc;
            if (bit_inc >= 4'd8) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              sda_reg_next    = shift_reg[7];
              shift_reg_next  = {shift_reg[6:0], 1'b0};
              unit_left_next  = 3'd2;
              wait_count_next = '0;
              phase_next      = PH_WR_SETUP;
            end
          end
          PH_ACK_SET: begin
            poll_count_next = '0;
            phase_next      = PH_POLL;
          end
          PH_RD_LOW: begin
            // sample SDA on the tick SCL rises
            scl_reg_next    = 1'b1;
            shift_reg_next  = {shift_reg[6:0], cmd.sda_in};
            bit_count_next  = bit_inc;
            unit_left_next  = 3'd1;
            wait_count_next = '0;
            phase_next      = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            scl_reg_next    = 1'b0;
            unit_left_next  = 3'd2;
            wait_count_next = '0;
            if (bit_count >= 4'd8) begin
              rx_hold_next   = shift_reg;
              drive_reg_next = 1'b1;
              sda_reg_next   = !ack_choice;
              phase_next     = PH_AK_LOW;
            end else begin
              phase_next = PH_RD_LOW;
            end
          end
          PH_AK_LOW: begin
            scl_reg_next    = 1'b1;
            unit_left_next  = 3'd2;
            wait_count_next = '0;
            phase_next      = PH_AK_HIGH;
          end
          PH_AK_HIGH: begin
            scl_reg_next = 1'b0;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      wait_count   <= '0;
      unit_left    <= '0;
      shift_reg    <= '0;
      poll_count   <= '0;
      scl_reg      <= 1'b1;
      sda_reg      <= 1'b1;
      drive_reg    <= 1'b1;
      ack_fail_reg <= 1'b0;
      rx_hold      <= '0;
      ack_choice   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      wait_count   <= wait_count_next;
      unit_left    <= unit_left_next;
      shift_reg    <= shift_reg_next;
      poll_count   <= poll_count_next;
      scl_reg      <= scl_reg_next;
      sda_reg      <= sda_reg_next;
      drive_reg    <= drive_reg_next;
      ack_fail_reg <= ack_fail_reg_next;
      rx_hold      <= rx_hold_next;
      ack_choice   <= ack_choice_next;
    end
  end

  always_comb begin
    res.scl_level   = scl_reg_next;
    res.sda_level   = sda_reg_next;
    res.sda_enable  = drive_reg_next;
    res.busy_res    = phase_next != PH_IDLE;
    res.done_res    = done;
    res.rx_byte     = rx_hold_next;
    res.ack_missing = ack_fail_reg_next;
  end

  `I2CM_ASSERT_IMP(a_poll_released, phase == PH_POLL, !drive_reg && scl_reg,
                   "SDA driven or SCL low while polling for ack")
  `I2CM_ASSERT_IMP(a_delay_loaded,
                   phase != PH_IDLE && phase != PH_POLL && phase <= PH_AK_HIGH,
                   unit_left != 3'd0, "timed phase with no delay units left")
  `I2CM_ASSERT_IMP(a_bit_range, 1'b1, bit_count <= 4'd8, "bit count beyond a byte")

endmodule

`default_nettype wire
